// ===== hw/rtl/nvt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvt_pkg
// Shared types, widths and helpers for the nine-patch vertex transform.
// ----------------------------------------------------------------------------
package nvt_pkg;

  // Field widths
  localparam int W_SIZE  = 14;  // sizes and config registers
  localparam int W_MAT   = 20;  // Q4.16 matrix entry
  localparam int W_SHIFT = 24;  // Q16.8 translation
  localparam int W_IDX   = 4;   // vertex number
  localparam int W_POS   = 32;  // Q.8 result

  // Internal widths
  localparam int W_COORD = 26;  // grid line, Q.8
  localparam int W_T     = 25;  // translation plus anchor offset, Q.8
  localparam int W_PROD  = W_MAT + W_COORD;  // Q.24 product
  localparam int W_SUM   = 49;  // sum of two products and translation, Q.24
  localparam int W_RND   = W_SUM - 16;       // rounded, Q.8, before clamp

  localparam logic [W_IDX-1:0] LAST_VERTEX = 4'd15;
  localparam int W_CFG_INDEX = 3;

  // Configuration register indexes
  typedef enum logic [W_CFG_INDEX-1:0] {
    REG_SOURCE_WIDTH    = 3'd0,
    REG_SOURCE_HEIGHT   = 3'd1,
    REG_SCALABLE_LEFT   = 3'd2,
    REG_SCALABLE_TOP    = 3'd3,
    REG_SCALABLE_WIDTH  = 3'd4,
    REG_SCALABLE_HEIGHT = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [W_SIZE-1:0] source_width;
    logic [W_SIZE-1:0] source_height;
    logic [W_SIZE-1:0] scalable_left;
    logic [W_SIZE-1:0] scalable_top;
    logic [W_SIZE-1:0] scalable_width;
    logic [W_SIZE-1:0] scalable_height;
  } cfg_t;

  typedef struct packed {
    logic [W_SIZE-1:0]         width;
    logic [W_SIZE-1:0]         height;
    logic signed [W_MAT-1:0]   m_xx;
    logic signed [W_MAT-1:0]   m_xy;
    logic signed [W_MAT-1:0]   m_yx;
    logic signed [W_MAT-1:0]   m_yy;
    logic signed [W_SHIFT-1:0] shift_x;
    logic signed [W_SHIFT-1:0] shift_y;
    logic                      anchor_top_left;
  } req_t;

  // Sequencer output: one vertex of the held request
  typedef struct packed {
    logic             valid;
    logic [W_IDX-1:0] idx;
    req_t             req;
  } issue_t;

  // Grid stage: vertex position in Q.8 and translation
  typedef struct packed {
    logic                      valid;
    logic [W_IDX-1:0]          idx;
    logic signed [W_COORD-1:0] x;
    logic signed [W_COORD-1:0] y;
    logic signed [W_T-1:0]     tx;
    logic signed [W_T-1:0]     ty;
    logic signed [W_MAT-1:0]   m_xx;
    logic signed [W_MAT-1:0]   m_xy;
    logic signed [W_MAT-1:0]   m_yx;
    logic signed [W_MAT-1:0]   m_yy;
  } coord_t;

  // Multiply stage: four Q.24 products
  typedef struct packed {
    logic                     valid;
    logic [W_IDX-1:0]         idx;
    logic signed [W_PROD-1:0] p_xx;
    logic signed [W_PROD-1:0] p_yx;
    logic signed [W_PROD-1:0] p_xy;
    logic signed [W_PROD-1:0] p_yy;
    logic signed [W_T-1:0]    tx;
    logic signed [W_T-1:0]    ty;
  } prod_t;

  // Round stage: rounded Q.8 values, not yet clamped
  typedef struct packed {
    logic                    valid;
    logic [W_IDX-1:0]        idx;
    logic signed [W_RND-1:0] rx;
    logic signed [W_RND-1:0] ry;
  } rnd_t;

  // One of the four grid lines along an axis, Q.8
  function automatic logic signed [W_COORD-1:0] grid_line(
    input logic [W_SIZE-1:0] size,
    input logic [W_SIZE-1:0] src,
    input logic [W_SIZE-1:0] start,
    input logic [W_SIZE-1:0] span,
    input logic [1:0]        sel
  );
    logic signed [W_COORD-1:0] half;
    logic signed [W_COORD-1:0] lo;
    logic signed [W_COORD-1:0] d;
    logic signed [W_COORD-1:0] res;
    half = $signed({5'b0, size, 7'b0});
    lo   = -half;
    d    = $signed({12'b0, src}) - $signed({12'b0, start}) - $signed({12'b0, span});
    case (sel)
      2'd0:    res = lo;
      2'd1:    res = lo + $signed({4'b0, start, 8'b0});
      2'd2:    res = half - (d <<< 8);
      default: res = half;
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/nvt_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvt_seq
// Holds one request and issues its sixteen vertices, one per pipeline step.
// ----------------------------------------------------------------------------
module nvt_seq import nvt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  logic   in_valid,
  output logic   in_stall,
  input  req_t   in_req,
  output issue_t issue
);

  logic             busy;
  logic [W_IDX-1:0] cnt;
  req_t             req;
  logic             take;

  // New request when empty or when the final vertex leaves this cycle
  assign in_stall = rst || (busy && !(adv && (cnt == LAST_VERTEX)));
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (take) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy && adv) begin
      cnt <= cnt + 4'd1;
      if (cnt == LAST_VERTEX) begin
        busy <= 1'b0;
      end
    end
  end

  // Request payload
  always_ff @(posedge clk) begin
    if (take) begin
      req <= in_req;
    end
  end

  assign issue.valid = busy;
  assign issue.idx   = cnt;
  assign issue.req   = req;

endmodule

// ===== hw/rtl/nvt_grid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvt_grid
// Grid stage: picks the column and row line for the vertex and forms the
// translation with the optional top-left anchor offset.
// ----------------------------------------------------------------------------
module nvt_grid import nvt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  cfg_t   cfg,
  input  issue_t issue,
  output coord_t coord
);

  coord_t                    coord_next;
  logic signed [W_T-1:0]     off_x;
  logic signed [W_T-1:0]     off_y;

  // Half size in Q.8 when anchored at the top-left corner
  assign off_x = issue.req.anchor_top_left ? $signed({4'b0, issue.req.width, 7'b0}) : '0;
  assign off_y = issue.req.anchor_top_left ? $signed({4'b0, issue.req.height, 7'b0}) : '0;

  always_comb begin
    coord_next.valid = issue.valid;
    coord_next.idx   = issue.idx;
    coord_next.x     = grid_line(issue.req.width, cfg.source_width, cfg.scalable_left,
                                 cfg.scalable_width, issue.idx[1:0]);
    coord_next.y     = grid_line(issue.req.height, cfg.source_height, cfg.scalable_top,
                                 cfg.scalable_height, issue.idx[3:2]);
    coord_next.tx    = W_T'(issue.req.shift_x) + off_x;
    coord_next.ty    = W_T'(issue.req.shift_y) + off_y;
    coord_next.m_xx  = issue.req.m_xx;
    coord_next.m_xy  = issue.req.m_xy;
    coord_next.m_yx  = issue.req.m_yx;
    coord_next.m_yy  = issue.req.m_yy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coord.valid <= 1'b0;
    end else if (adv) begin
      coord.valid <= coord_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      coord.idx  <= coord_next.idx;
      coord.x    <= coord_next.x;
      coord.y    <= coord_next.y;
      coord.tx   <= coord_next.tx;
      coord.ty   <= coord_next.ty;
      coord.m_xx <= coord_next.m_xx;
      coord.m_xy <= coord_next.m_xy;
      coord.m_yx <= coord_next.m_yx;
      coord.m_yy <= coord_next.m_yy;
    end
  end

endmodule

// ===== hw/rtl/nvt_xform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvt_xform
// Two stages: four 20x26 products, then the Q.24 sums rounded half up to Q.8.
// ----------------------------------------------------------------------------
module nvt_xform import nvt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  coord_t coord,
  output rnd_t   rnd
);

  prod_t                    prod;
  logic signed [W_SUM-1:0]  sum_x;
  logic signed [W_SUM-1:0]  sum_y;
  logic signed [W_SUM-1:0]  t_x;
  logic signed [W_SUM-1:0]  t_y;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod.valid <= 1'b0;
    end else if (adv) begin
      prod.valid <= coord.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod.idx  <= coord.idx;
      prod.p_xx <= coord.m_xx * coord.x;
      prod.p_yx <= coord.m_yx * coord.y;
      prod.p_xy <= coord.m_xy * coord.x;
      prod.p_yy <= coord.m_yy * coord.y;
      prod.tx   <= coord.tx;
      prod.ty   <= coord.ty;
    end
  end

  // Sum and round: add half an output LSB, then floor
  assign t_x   = W_SUM'($signed({prod.tx, 16'b0}));
  assign t_y   = W_SUM'($signed({prod.ty, 16'b0}));
  assign sum_x = W_SUM'(prod.p_xx) + W_SUM'(prod.p_yx) + t_x + 49'sd32768;
  assign sum_y = W_SUM'(prod.p_xy) + W_SUM'(prod.p_yy) + t_y + 49'sd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd.valid <= 1'b0;
    end else if (adv) begin
      rnd.valid <= prod.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rnd.idx <= prod.idx;
      rnd.rx  <= sum_x[W_SUM-1:16];
      rnd.ry  <= sum_y[W_SUM-1:16];
    end
  end

endmodule

// ===== hw/rtl/nvt_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvt_out
// Output stage: clamps to the signed 32-bit range and holds the result
// until the receiver takes it.
// ----------------------------------------------------------------------------
module nvt_out import nvt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  rnd_t                    rnd,
  output logic                    out_valid,
  output logic [W_IDX-1:0]        vertex_index,
  output logic signed [W_POS-1:0] pos_x,
  output logic signed [W_POS-1:0] pos_y,
  output logic                    last
);

  logic signed [W_POS-1:0] sat_x;
  logic signed [W_POS-1:0] sat_y;

  // Clamp when the top two bits disagree
  always_comb begin
    if (rnd.rx[W_RND-1] != rnd.rx[W_RND-2]) begin
      sat_x = rnd.rx[W_RND-1] ? {1'b1, {(W_POS-1){1'b0}}} : {1'b0, {(W_POS-1){1'b1}}};
    end else begin
      sat_x = rnd.rx[W_POS-1:0];
    end
    if (rnd.ry[W_RND-1] != rnd.ry[W_RND-2]) begin
      sat_y = rnd.ry[W_RND-1] ? {1'b1, {(W_POS-1){1'b0}}} : {1'b0, {(W_POS-1){1'b1}}};
    end else begin
      sat_y = rnd.ry[W_POS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= rnd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vertex_index <= rnd.idx;
      pos_x        <= sat_x;
      pos_y        <= sat_y;
      last         <= (rnd.idx == LAST_VERTEX);
    end
  end

endmodule

// ===== hw/rtl/nine_patch_vertex_transform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nine_patch_vertex_transform
// Nine-slice vertex grid generator with a 2x2 affine transform.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one sprite request: size,
//   Q4.16 matrix, Q16.8 translation and the top-left anchor flag.
//   Output channel (out_valid / out_stall) returns 16 vertices in row-major
//   order, vertex_index 0..15, with last set on vertex 15.
//   Configuration is a write port (cfg_we, cfg_index, cfg_data); write it
//   only while no request is in flight. Unknown indexes are ignored.
// Timing:
//   The first vertex passes the sequencer, grid, multiply, sum/round and
//   output registers after the request is taken, then one vertex per cycle
//   follows while out_stall does not hold the output. A request occupies
//   the sequencer until its last vertex issues; the next one is taken then.
//   Pipeline: sequencer, grid, multiply, sum/round, clamp/output register.
// Reset: rst (synchronous) empties the pipeline and clears the configuration registers.
// Stall: while out_stall holds a valid result, the pipeline freezes, but an
//   empty sequencer may still take a request; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module nine_patch_vertex_transform import nvt_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_we,
  input  logic [W_CFG_INDEX-1:0]       cfg_index,
  input  logic [W_SIZE-1:0]            cfg_data,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [W_SIZE-1:0]            width,
  input  logic [W_SIZE-1:0]            height,
  input  logic signed [W_MAT-1:0]      m_xx,
  input  logic signed [W_MAT-1:0]      m_xy,
  input  logic signed [W_MAT-1:0]      m_yx,
  input  logic signed [W_MAT-1:0]      m_yy,
  input  logic signed [W_SHIFT-1:0]    shift_x,
  input  logic signed [W_SHIFT-1:0]    shift_y,
  input  logic                         anchor_top_left,
  // vertex channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [W_IDX-1:0]             vertex_index,
  output logic signed [W_POS-1:0]      pos_x,
  output logic signed [W_POS-1:0]      pos_y,
  output logic                         last
);

  cfg_t   cfg;
  req_t   in_req;
  issue_t issue;
  coord_t coord;
  rnd_t   rnd;
  logic   adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:    cfg.source_width    <= cfg_data;
        REG_SOURCE_HEIGHT:   cfg.source_height   <= cfg_data;
        REG_SCALABLE_LEFT:   cfg.scalable_left   <= cfg_data;
        REG_SCALABLE_TOP:    cfg.scalable_top    <= cfg_data;
        REG_SCALABLE_WIDTH:  cfg.scalable_width  <= cfg_data;
        REG_SCALABLE_HEIGHT: cfg.scalable_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline moves unless a held result is stalled
  assign adv = !out_valid || !out_stall;

  always_comb begin
    in_req.width           = width;
    in_req.height          = height;
    in_req.m_xx            = m_xx;
    in_req.m_xy            = m_xy;
    in_req.m_yx            = m_yx;
    in_req.m_yy            = m_yy;
    in_req.shift_x         = shift_x;
    in_req.shift_y         = shift_y;
    in_req.anchor_top_left = anchor_top_left;
  end

  nvt_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .issue    (issue)
  );

  nvt_grid u_grid (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .cfg   (cfg),
    .issue (issue),
    .coord (coord)
  );

  nvt_xform u_xform (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .coord (coord),
    .rnd   (rnd)
  );

  nvt_out u_out (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .rnd          (rnd),
    .out_valid    (out_valid),
    .vertex_index (vertex_index),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .last         (last)
  );

endmodule

// ===== hw/rtl/nvt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvt_checker
// Port-level checks for the vertex channel, bound to the top level.
// ----------------------------------------------------------------------------
module nvt_checker import nvt_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [W_IDX-1:0]        vertex_index,
  input logic signed [W_POS-1:0] pos_x,
  input logic signed [W_POS-1:0] pos_y,
  input logic                    last
);

  // A stalled vertex stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(vertex_index) &&
      $stable(pos_x) && $stable(pos_y) && $stable(last))
    else $error("stalled vertex changed");

  // last marks exactly the final vertex
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (vertex_index == LAST_VERTEX)))
    else $error("last does not match vertex 15");

  // Within a run the vertices follow without gaps
  a_run_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && (vertex_index != LAST_VERTEX) |=>
      out_valid && (vertex_index == $past(vertex_index) + 4'd1))
    else $error("vertex run broken");

  // A run starts at vertex 0
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && (vertex_index == LAST_VERTEX) ##1 out_valid |->
      (vertex_index == '0))
    else $error("run does not start at vertex 0");

endmodule

bind nine_patch_vertex_transform nvt_checker u_nvt_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .vertex_index (vertex_index),
  .pos_x        (pos_x),
  .pos_y        (pos_y),
  .last         (last)
);
